>>> hdl/stt_pkg.sv
package stt_pkg;

	// default counter widths
	localparam int INDEX_BITS_DEF  = 24;
	localparam int LINE_BITS_DEF   = 20;
	localparam int COLUMN_BITS_DEF = 16;

	localparam int KIND_W    = 5;
	localparam int MAX_TOKS  = 3;   // most tokens one byte can release
	localparam int CNT_W     = 2;
	localparam int Q_DEPTH   = 2;

	localparam logic [KIND_W-1:0] K_PLUS    = 5'd0;
	localparam logic [KIND_W-1:0] K_MINUS   = 5'd1;
	localparam logic [KIND_W-1:0] K_STAR    = 5'd2;
	localparam logic [KIND_W-1:0] K_SLASH   = 5'd3;
	localparam logic [KIND_W-1:0] K_DOT     = 5'd4;
	localparam logic [KIND_W-1:0] K_COMMA   = 5'd5;
	localparam logic [KIND_W-1:0] K_EQUALS  = 5'd6;
	localparam logic [KIND_W-1:0] K_LPAREN  = 5'd7;
	localparam logic [KIND_W-1:0] K_RPAREN  = 5'd8;
	localparam logic [KIND_W-1:0] K_LBRACE  = 5'd9;
	localparam logic [KIND_W-1:0] K_RBRACE  = 5'd10;
	localparam logic [KIND_W-1:0] K_IDENT   = 5'd11;
	localparam logic [KIND_W-1:0] K_NUMBER  = 5'd12;
	localparam logic [KIND_W-1:0] K_STRING  = 5'd13;
	localparam logic [KIND_W-1:0] K_UNTERM  = 5'd14;
	localparam logic [KIND_W-1:0] K_UNKNOWN = 5'd15;
	localparam logic [KIND_W-1:0] K_EOF     = 5'd16;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_US     = 8'h5F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	function automatic logic is_digit(input logic [7:0] ch);
		return ch >= 8'h30 && ch <= 8'h39;
	endfunction

	function automatic logic is_letter(input logic [7:0] ch);
		return (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
	endfunction

	function automatic logic is_word(input logic [7:0] ch);
		return is_letter(ch) || is_digit(ch) || ch == CH_US;
	endfunction

endpackage

>>> hdl/stt_front.sv
module stt_front #(
	parameter int INDEX_BITS  = stt_pkg::INDEX_BITS_DEF,
	parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF,
	parameter int BUN_W = stt_pkg::CNT_W + stt_pkg::MAX_TOKS *
		(stt_pkg::KIND_W + 2*INDEX_BITS + 2*LINE_BITS + 2*COLUMN_BITS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [7:0]       char_code,
	input  logic             end_of_text,
	output logic             push,
	output logic [BUN_W-1:0] bundle
);
	import stt_pkg::*;

	localparam int IB = INDEX_BITS;
	localparam int LB = LINE_BITS;
	localparam int CB = COLUMN_BITS;

	typedef enum logic [7:0] {
		M_IDLE     = 8'b0000_0001,
		M_AFTER_CR = 8'b0000_0010,
		M_IDENT    = 8'b0000_0100,
		M_NUM_INT  = 8'b0000_1000,
		M_NUM_US   = 8'b0001_0000,
		M_NUM_DOT  = 8'b0010_0000,
		M_NUM_FRAC = 8'b0100_0000,
		M_STRING   = 8'b1000_0000
	} mode_t;

	typedef struct packed {
		mode_t           mode;
		logic [IB-1:0]   p;
		logic [IB-1:0]   tp;
		logic [LB-1:0]   l;
		logic [LB-1:0]   tl;
		logic [CB-1:0]   c;
		logic [CB-1:0]   tc;
	} st_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [IB-1:0]     sp;
		logic [IB-1:0]     ep;
		logic [LB-1:0]     sl;
		logic [CB-1:0]     sc;
		logic [LB-1:0]     el;
		logic [CB-1:0]     ec;
	} tok_t;

	localparam st_t ST_RESET = '{mode: M_IDLE, p: '0, tp: '0,
		l: LB'(1), tl: LB'(1), c: CB'(1), tc: CB'(1)};

	function automatic logic [IB-1:0] inc_p(input logic [IB-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction
	function automatic logic [LB-1:0] inc_l(input logic [LB-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction
	function automatic logic [CB-1:0] inc_c(input logic [CB-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic st_t adv(input st_t s);
		st_t r;
		r = s;
		r.p = inc_p(s.p);
		r.c = inc_c(s.c);
		return r;
	endfunction

	function automatic tok_t lexeme(input st_t s, input logic [KIND_W-1:0] k);
		return '{kind: k, sp: s.tp, ep: s.p, sl: s.tl, sc: s.tc, el: s.l, ec: s.c};
	endfunction

	function automatic tok_t single(input st_t s, input logic [KIND_W-1:0] k,
			input logic wide);
		return '{kind: k, sp: s.p, ep: wide ? inc_p(s.p) : s.p, sl: s.l, sc: s.c,
			el: s.l, ec: wide ? inc_c(s.c) : s.c};
	endfunction

	function automatic logic [KIND_W:0] op_kind(input logic [7:0] ch);
		logic [KIND_W:0] r;
		unique case (ch)
			CH_PLUS:   r = {1'b1, K_PLUS};
			CH_MINUS:  r = {1'b1, K_MINUS};
			CH_STAR:   r = {1'b1, K_STAR};
			CH_SLASH:  r = {1'b1, K_SLASH};
			CH_DOT:    r = {1'b1, K_DOT};
			CH_COMMA:  r = {1'b1, K_COMMA};
			CH_EQUALS: r = {1'b1, K_EQUALS};
			CH_LPAREN: r = {1'b1, K_LPAREN};
			CH_RPAREN: r = {1'b1, K_RPAREN};
			CH_LBRACE: r = {1'b1, K_LBRACE};
			CH_RBRACE: r = {1'b1, K_RBRACE};
			default:   r = '0;
		endcase
		return r;
	endfunction

	// byte seen between tokens
	function automatic void idle_byte(input st_t s, input logic [7:0] ch, input logic e,
			output st_t so, output tok_t t, output logic v, output logic fin);
		logic [KIND_W:0] op;
		op  = op_kind(ch);
		so  = s;
		so.mode = M_IDLE;
		t   = '0;
		v   = 1'b0;
		fin = 1'b0;
		if (e) begin
			t = single(s, K_EOF, 1'b0);
			v = 1'b1;
			fin = 1'b1;
			so = adv(so);
		end else if (ch == CH_CR || ch == CH_LF) begin
			so.p = inc_p(s.p);
			so.l = inc_l(s.l);
			so.c = CB'(1);
			if (ch == CH_CR)
				so.mode = M_AFTER_CR;
		end else if (ch == CH_TAB || ch == CH_SPACE) begin
			so = adv(so);
		end else if (op[KIND_W]) begin
			t = single(s, op[KIND_W-1:0], 1'b1);
			v = 1'b1;
			so = adv(so);
		end else if (ch == CH_QUOTE || is_letter(ch) || ch == CH_US || is_digit(ch)) begin
			so.tp = s.p;
			so.tl = s.l;
			so.tc = s.c;
			so = adv(so);
			if (ch == CH_QUOTE)
				so.mode = M_STRING;
			else if (is_digit(ch))
				so.mode = M_NUM_INT;
			else
				so.mode = M_IDENT;
		end else begin
			t = single(s, K_UNKNOWN, 1'b0);
			v = 1'b1;
			so = adv(so);
		end
	endfunction

	st_t                    cur_q, s, sn;
	logic                   done_q;
	tok_t [MAX_TOKS-1:0]    tk;
	tok_t                   t;
	logic [CNT_W-1:0]       n;
	logic                   v, f, fin, e, run_int, take;

	assign e    = end_of_text || char_code == CH_NUL;
	assign take = in_valid && !in_stall && !done_q;

	always_comb begin
		s       = cur_q;
		sn      = cur_q;
		tk      = '0;
		t       = '0;
		n       = '0;
		v       = 1'b0;
		f       = 1'b0;
		fin     = 1'b0;
		run_int = 1'b0;
		unique case (cur_q.mode)
			M_AFTER_CR: begin
				s.mode = M_IDLE;
				if (!e && char_code == CH_LF) begin
					s.p = inc_p(s.p);
				end else begin
					idle_byte(s, char_code, e, sn, t, v, f);
					s = sn;
					if (v) begin tk[n] = t; n = n + 1'b1; end
					fin = f;
				end
			end
			M_IDENT: begin
				if (!e && is_word(char_code)) begin
					s = adv(s);
				end else begin
					tk[n] = lexeme(s, K_IDENT);
					n = n + 1'b1;
					idle_byte(s, char_code, e, sn, t, v, f);
					s = sn;
					if (v) begin tk[n] = t; n = n + 1'b1; end
					fin = f;
				end
			end
			M_NUM_INT: run_int = 1'b1;
			M_NUM_US: begin
				if (!e && char_code == CH_DOT) begin
					// number stops before the underscore, which stands alone
					tk[n] = lexeme(s, K_NUMBER);
					n = n + 1'b1;
					idle_byte(s, CH_US, 1'b0, sn, t, v, f);
					s = sn;
					tk[n] = lexeme(s, K_IDENT);
					n = n + 1'b1;
					idle_byte(s, char_code, 1'b0, sn, t, v, f);
					s = sn;
					if (v) begin tk[n] = t; n = n + 1'b1; end
				end else begin
					s = adv(s);
					s.mode = M_NUM_INT;
					run_int = 1'b1;
				end
			end
			M_NUM_DOT: begin
				if (!e && is_digit(char_code)) begin
					s = adv(adv(s));
					s.mode = M_NUM_FRAC;
				end else begin
					tk[n] = lexeme(s, K_NUMBER);
					n = n + 1'b1;
					tk[n] = single(s, K_DOT, 1'b1);
					n = n + 1'b1;
					s = adv(s);
					idle_byte(s, char_code, e, sn, t, v, f);
					s = sn;
					if (v) begin tk[n] = t; n = n + 1'b1; end
					fin = f;
				end
			end
			M_NUM_FRAC: begin
				if (!e && (is_digit(char_code) || char_code == CH_US)) begin
					s = adv(s);
				end else begin
					tk[n] = lexeme(s, K_NUMBER);
					n = n + 1'b1;
					idle_byte(s, char_code, e, sn, t, v, f);
					s = sn;
					if (v) begin tk[n] = t; n = n + 1'b1; end
					fin = f;
				end
			end
			M_STRING: begin
				if (e) begin
					tk[n] = lexeme(s, K_UNTERM);
					n = n + 1'b1;
					idle_byte(s, char_code, e, sn, t, v, f);
					s = sn;
					if (v) begin tk[n] = t; n = n + 1'b1; end
					fin = f;
				end else if (char_code == CH_QUOTE) begin
					s = adv(s);
					tk[n] = lexeme(s, K_STRING);
					n = n + 1'b1;
					s.mode = M_IDLE;
				end else begin
					s = adv(s);
				end
			end
			default: begin
				idle_byte(s, char_code, e, sn, t, v, f);
				s = sn;
				if (v) begin tk[n] = t; n = n + 1'b1; end
				fin = f;
			end
		endcase
		if (run_int) begin
			if (!e && is_digit(char_code)) begin
				s = adv(s);
			end else if (!e && char_code == CH_US) begin
				s.mode = M_NUM_US;
			end else if (!e && char_code == CH_DOT) begin
				s.mode = M_NUM_DOT;
			end else begin
				tk[n] = lexeme(s, K_NUMBER);
				n = n + 1'b1;
				idle_byte(s, char_code, e, sn, t, v, f);
				s = sn;
				if (v) begin tk[n] = t; n = n + 1'b1; end
				fin = f;
			end
		end
	end

	assign push   = take && n != '0;
	assign bundle = {n, tk};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= ST_RESET;
			done_q <= 1'b0;
		end else if (take) begin
			cur_q  <= s;
			done_q <= fin;
		end
	end

endmodule

>>> hdl/stt_queue.sv
module stt_queue #(
	parameter int BUN_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [BUN_W-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic             avail,
	output logic [BUN_W-1:0] rd_data
);
	import stt_pkg::*;

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(Q_DEPTH - 1);

	logic [BUN_W-1:0] mem_q [Q_DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = cnt_q == CW'(Q_DEPTH);
	assign avail   = cnt_q != '0;
	assign do_push = push && !full;
	assign do_pop  = pop && avail;
	assign rd_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

>>> hdl/stt_back.sv
module stt_back #(
	parameter int INDEX_BITS  = stt_pkg::INDEX_BITS_DEF,
	parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF,
	parameter int BUN_W = stt_pkg::CNT_W + stt_pkg::MAX_TOKS *
		(stt_pkg::KIND_W + 2*INDEX_BITS + 2*LINE_BITS + 2*COLUMN_BITS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_avail,
	input  logic [BUN_W-1:0]              q_data,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [stt_pkg::KIND_W-1:0]    token_kind,
	output logic [INDEX_BITS-1:0]         start_position,
	output logic [INDEX_BITS-1:0]         end_position,
	output logic [LINE_BITS-1:0]          start_line,
	output logic [COLUMN_BITS-1:0]        start_column,
	output logic [LINE_BITS-1:0]          end_line,
	output logic [COLUMN_BITS-1:0]        end_column,
	output logic                          last_of_run
);
	import stt_pkg::*;

	typedef struct packed {
		logic [KIND_W-1:0]      kind;
		logic [INDEX_BITS-1:0]  sp;
		logic [INDEX_BITS-1:0]  ep;
		logic [LINE_BITS-1:0]   sl;
		logic [COLUMN_BITS-1:0] sc;
		logic [LINE_BITS-1:0]   el;
		logic [COLUMN_BITS-1:0] ec;
	} tok_t;

	logic [BUN_W-1:0]    bun_q;
	logic [CNT_W-1:0]    idx_q, cnt;
	logic                vld_q, done_tok;
	tok_t [MAX_TOKS-1:0] toks;
	tok_t                cur;

	assign cnt  = bun_q[BUN_W-1 -: CNT_W];
	assign toks = bun_q[BUN_W-CNT_W-1:0];
	assign cur  = toks[idx_q];

	assign out_valid   = vld_q;
	assign last_of_run = idx_q == cnt - 1'b1;
	assign done_tok    = vld_q && !out_stall && last_of_run;
	assign q_pop       = q_avail && (!vld_q || done_tok);

	assign token_kind     = cur.kind;
	assign start_position = cur.sp;
	assign end_position   = cur.ep;
	assign start_line     = cur.sl;
	assign start_column   = cur.sc;
	assign end_line       = cur.el;
	assign end_column     = cur.ec;

	always_ff @(posedge clk) begin
		if (q_pop)
			bun_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (q_pop) begin
			vld_q <= 1'b1;
			idx_q <= '0;
		end else if (done_tok) begin
			vld_q <= 1'b0;
		end else if (vld_q && !out_stall) begin
			idx_q <= idx_q + 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> idx_q < cnt)
		else $error("token index past bundle count");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && !out_stall && !last_of_run) |=> vld_q && idx_q == $past(idx_q) + 1'b1)
		else $error("token index did not step");
	a_pop_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!vld_q || done_tok))
		else $error("bundle loaded over a pending token");
`endif

endmodule

>>> hdl/source_text_tokenizer.sv
// Streaming tokenizer: takes one source byte per request on the input side and
// returns tokens (kind, start/end index, start/end line and column) on the output
// side, with last_of_run marking the final token a byte released. Bytes are
// accepted back to back while the queue has room; a byte releases up to three
// tokens, and the output side sends one token per cycle while out_stall is low. A
// two-entry queue of token bundles between the lexer and the output stage absorbs
// these bursts and stalls on the output side. A zero byte or end_of_text closes the
// text with an end-of-file token; later requests are taken and dropped until reset.
// Counters saturate at their width.
module source_text_tokenizer #(
	parameter int INDEX_BITS  = stt_pkg::INDEX_BITS_DEF,
	parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    char_code,
	input  logic                          end_of_text,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [stt_pkg::KIND_W-1:0]    token_kind,
	output logic [INDEX_BITS-1:0]         start_position,
	output logic [INDEX_BITS-1:0]         end_position,
	output logic [LINE_BITS-1:0]          start_line,
	output logic [COLUMN_BITS-1:0]        start_column,
	output logic [LINE_BITS-1:0]          end_line,
	output logic [COLUMN_BITS-1:0]        end_column,
	output logic                          last_of_run
);
	import stt_pkg::*;

	// one bundle: token count plus the tokens a single byte can release
	localparam int BUN_W = CNT_W + MAX_TOKS *
		(KIND_W + 2*INDEX_BITS + 2*LINE_BITS + 2*COLUMN_BITS);

	logic             push, q_full, q_avail, q_pop;
	logic [BUN_W-1:0] bundle, q_data;

	// lexer takes a request whenever the queue has room
	assign in_stall = q_full;

	stt_front #(
		.INDEX_BITS(INDEX_BITS), .LINE_BITS(LINE_BITS),
		.COLUMN_BITS(COLUMN_BITS), .BUN_W(BUN_W)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.char_code(char_code), .end_of_text(end_of_text),
		.push(push), .bundle(bundle)
	);

	stt_queue #(.BUN_W(BUN_W)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wr_data(bundle), .full(q_full),
		.pop(q_pop), .avail(q_avail), .rd_data(q_data)
	);

	stt_back #(
		.INDEX_BITS(INDEX_BITS), .LINE_BITS(LINE_BITS),
		.COLUMN_BITS(COLUMN_BITS), .BUN_W(BUN_W)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_avail(q_avail), .q_data(q_data), .q_pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.token_kind(token_kind),
		.start_position(start_position), .end_position(end_position),
		.start_line(start_line), .start_column(start_column),
		.end_line(end_line), .end_column(end_column),
		.last_of_run(last_of_run)
	);

endmodule
